// ===== rtl/core/stins_pkg.sv =====
`timescale 1ns / 1ps
// stins_pkg: shared widths, status codes and controller state type for the
// sorted table insert block. No dependencies.
package stins_pkg;

  // field widths
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;

  // table defaults
  localparam int               DEPTH_DEF = 64;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_RESP
  } state_t;

endpackage

// ===== rtl/core/stins_in_if.sv =====
`timescale 1ns / 1ps
// stins_in_if: input channel carrying one key/payload word per handshake.
// Depends on stins_pkg for field widths.
interface stins_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [stins_pkg::KEY_W-1:0] new_key;
  logic [stins_pkg::DATA_W-1:0]   payload;

  modport source (output valid, output new_key, output payload, input ready);
  modport sink   (input valid, input new_key, input payload, output ready);
endinterface

// ===== rtl/core/stins_out_if.sv =====
`timescale 1ns / 1ps
// stins_out_if: result channel carrying status and entry count per word.
// Depends on stins_pkg for field widths.
interface stins_out_if;
  logic                           valid;
  logic                           ready;
  logic [stins_pkg::STATUS_W-1:0] status;
  logic [stins_pkg::CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== rtl/core/stins_ram.sv =====
`timescale 1ns / 1ps
// stins_ram: generic simple dual-port RAM, one write and one registered read
// per cycle. No dependencies.
module stins_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/sorted_table_insert_core.sv =====
`timescale 1ns / 1ps
// sorted_table_insert_core: top level of the sorted key/payload table.
// Depends on stins_pkg, stins_in_if, stins_out_if and stins_ram.
//
// Usage:
//   item   : input channel, one signed key and one payload word per word.
//   result : output channel, status (inserted, full, duplicate) and the
//            entry count after the insert, one word per input word.
//   cfg_we / cfg_wdata : writes the capacity register (reset value 64);
//            write only while the block is idle.
// The table sits in one RAM (key and payload side by side) with a registered
// read. An insert scans downward from the top entry until it finds a key
// not above the new one (one read per cycle), then moves the larger entries
// up one place (one read and one write per cycle), then writes the new pair.
// A new word is taken only when the controller is idle; a finished result
// waits in the output register, so one more word may be accepted while the
// receiver stalls. Reset empties the table (count to zero) and the output.
module sorted_table_insert_core #(
  parameter int DEPTH = stins_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [stins_pkg::CNT_W-1:0] cfg_wdata,
  stins_in_if.sink                    item,
  stins_out_if.source                 result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (AW > stins_pkg::CNT_W) ? AW : stins_pkg::CNT_W;
  localparam int LW = XW + 1;
  localparam int EW = stins_pkg::KEY_W + stins_pkg::DATA_W;

  stins_pkg::state_t state, state_next;

  logic [stins_pkg::CNT_W-1:0]    capacity;
  logic [stins_pkg::CNT_W-1:0]    count, count_next;
  logic [AW-1:0]                  idx, idx_next;
  logic [AW-1:0]                  pos, pos_next;
  logic [stins_pkg::STATUS_W-1:0] sts, sts_next;
  logic [stins_pkg::KEY_W-1:0]    key_r;
  logic [stins_pkg::DATA_W-1:0]   data_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [XW-1:0]               count_x;
  logic [AW-1:0]               count_addr;
  logic [AW-1:0]               top_addr;
  logic                        is_full;
  logic                        accept;
  logic                        out_free;
  logic [stins_pkg::KEY_W-1:0] rd_key;
  logic                        key_hit;
  logic                        key_less;

  // table RAM, key in the upper half, payload in the lower half
  stins_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // count as table address, top occupied entry, full check
  assign count_x    = XW'(count);
  assign count_addr = count_x[AW-1:0];
  assign top_addr   = count_addr - AW'(1);
  assign is_full    = (count >= capacity) || (LW'(count) >= LW'(DEPTH));

  // handshakes
  assign item.ready = (state == stins_pkg::S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !result.valid || result.ready;

  // compare of the word read back against the new key
  assign rd_key   = mem_rdata[EW-1 -: stins_pkg::KEY_W];
  assign key_hit  = (rd_key == key_r);
  assign key_less = ($signed(key_r) < $signed(rd_key));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      stins_pkg::S_IDLE: begin
        if (accept) begin
          if (is_full) begin
            state_next = stins_pkg::S_RESP;
          end else if (count == '0) begin
            state_next = stins_pkg::S_PUT;
          end else begin
            state_next = stins_pkg::S_SCAN;
          end
        end
      end
      stins_pkg::S_SCAN: begin
        if (key_hit) begin
          state_next = stins_pkg::S_RESP;
        end else if (key_less) begin
          if (idx == '0) begin
            state_next = stins_pkg::S_SHIFT;
          end
        end else if ((idx + AW'(1)) == count_addr) begin
          state_next = stins_pkg::S_PUT;
        end else begin
          state_next = stins_pkg::S_SHIFT;
        end
      end
      stins_pkg::S_SHIFT: begin
        if (idx == pos) begin
          state_next = stins_pkg::S_PUT;
        end
      end
      stins_pkg::S_PUT: begin
        state_next = stins_pkg::S_RESP;
      end
      stins_pkg::S_RESP: begin
        if (out_free) begin
          state_next = stins_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = stins_pkg::S_IDLE;
      end
    endcase
  end

  // memory controls and datapath next values
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = {key_r, data_r};
    mem_raddr  = idx;
    idx_next   = idx;
    pos_next   = pos;
    sts_next   = sts;
    count_next = count;
    case (state)
      stins_pkg::S_IDLE: begin
        if (accept) begin
          if (is_full) begin
            sts_next = stins_pkg::ST_FULL;
          end else if (count == '0) begin
            pos_next = '0;
          end else begin
            mem_raddr = top_addr;
            idx_next  = top_addr;
          end
        end
      end
      stins_pkg::S_SCAN: begin
        if (key_hit) begin
          sts_next = stins_pkg::ST_DUPLICATE;
        end else if (key_less) begin
          if (idx == '0) begin
            // new key below every entry, move the whole table
            pos_next  = '0;
            mem_raddr = top_addr;
            idx_next  = top_addr;
          end else begin
            mem_raddr = idx - AW'(1);
            idx_next  = idx - AW'(1);
          end
        end else begin
          // gap lands just above this entry
          pos_next  = idx + AW'(1);
          mem_raddr = top_addr;
          idx_next  = top_addr;
        end
      end
      stins_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = idx + AW'(1);
        mem_wdata = mem_rdata;
        if (idx != pos) begin
          mem_raddr = idx - AW'(1);
          idx_next  = idx - AW'(1);
        end
      end
      stins_pkg::S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = pos;
        mem_wdata  = {key_r, data_r};
        count_next = count + stins_pkg::CNT_W'(1);
        sts_next   = stins_pkg::ST_INSERTED;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= stins_pkg::S_IDLE;
      count    <= '0;
      capacity <= stins_pkg::CAP_RESET;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  // working registers of the current insert
  always_ff @(posedge clk) begin
    idx <= idx_next;
    pos <= pos_next;
    sts <= sts_next;
    if (accept) begin
      key_r  <= item.new_key;
      data_r <= item.payload;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == stins_pkg::S_RESP && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == stins_pkg::S_RESP && out_free) begin
      result.status      <= sts;
      result.entry_count <= count;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_table_insert_core, with directed and random inserts
// checked against a behavioral table model. Depends on stins_pkg, stins_in_if, stins_out_if
// and the core.
module tb_top;
  import stins_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDLE_PCT = 17;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_LEN = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS = 800;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [STATUS_W-1:0]     status;
    logic [CNT_W-1:0]        count;
  } insert_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  stins_in_if  item_ch ();
  stins_out_if result_ch ();

  sorted_table_insert_core #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  // shadow of the table: keys in ascending order, fill count and capacity
  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int                      shadow_fill;
  logic [CNT_W-1:0]        shadow_cap;

  insert_result_t pending_q [$];
  int             mismatches;
  bit             no_idle;
  int             hold_request;
  int             sent_count;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // predict status and count for one accepted word, updating the shadow table
  function automatic insert_result_t predict_insert(logic signed [KEY_W-1:0] key);
    insert_result_t r;
    int lim;
    int i;
    int pos;
    lim = (int'(shadow_cap) < DEPTH) ? int'(shadow_cap) : DEPTH;
    r.key = key;
    r.status = ST_INSERTED;
    if (shadow_fill >= lim) begin
      r.status = ST_FULL;
    end else begin
      for (i = 0; i < shadow_fill; i++) begin
        if (shadow_keys[i] == key) r.status = ST_DUPLICATE;
      end
    end
    if (r.status == ST_INSERTED) begin
      pos = shadow_fill;
      while (pos > 0 && key < shadow_keys[pos-1]) begin
        shadow_keys[pos] = shadow_keys[pos-1];
        pos--;
      end
      shadow_keys[pos] = key;
      shadow_fill++;
    end
    r.count = shadow_fill[CNT_W-1:0];
    return r;
  endfunction

  // key mix: stored keys for duplicates, extremes, a narrow cluster, full range
  function automatic logic signed [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30 && shadow_fill > 0) return shadow_keys[$urandom_range(shadow_fill-1)];
    if (sel < 40) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    if (sel < 55) return $signed($urandom_range(40)) - 32'sd20;
    return $signed($urandom);
  endfunction

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input logic signed [KEY_W-1:0] key, input logic [DATA_W-1:0] data);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.new_key <= key;
    item_ch.payload <= data;
    do @(posedge clk); while (!item_ch.ready);
    pending_q.push_back(predict_insert(key));
    sent_count++;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_word(pick_key(), $urandom);
  endtask

  // stop offering and wait for every pending result, then let the block settle
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap = value;
  endtask

  // empty table at reset capacity, then keys and payloads at their extremes
  task automatic test_extremes();
    send_word(32'sd0, 32'h0000_0000);
    send_word(32'sh7fff_ffff, 32'hffff_ffff);
    send_word(32'sh8000_0000, 32'h0000_0000);
    send_word(-32'sd1, 32'hffff_ffff);
    send_word(32'sd1, 32'ha5a5_5a5a);
    send_word(32'sh4000_0000, 32'h5a5a_a5a5);
  endtask

  // stored keys offered again are refused as duplicate
  task automatic test_duplicates();
    send_word(32'sd0, 32'h1234_5678);
    send_word(32'sh7fff_ffff, 32'h0);
    send_word(32'sh8000_0000, 32'hffff_ffff);
    send_word(-32'sd1, 32'h0);
  endtask

  // capacity zero refuses everything
  task automatic test_capacity_zero();
    write_capacity(7'd0);
    send_word(32'sd99, 32'h0);
    send_word(32'sd0, 32'hffff_ffff);
  endtask

  // full wins over duplicate when the table is at its limit
  task automatic test_full_before_duplicate();
    write_capacity(shadow_fill[CNT_W-1:0]);
    send_word(32'sd1, 32'h0);
    send_word(32'sd12345, 32'h0);
  endtask

  // capacity below the count refuses, entries are kept once raised again
  task automatic test_capacity_lowered();
    write_capacity(7'd1);
    send_word(32'sd777, 32'h0);
    send_word(32'sh8000_0000, 32'h0);
    write_capacity(CAP_RESET);
    send_word(32'sh4000_0000, 32'h0);
    send_word(32'sd777, 32'hffff_ffff);
  endtask

  // capacity above the table depth is limited to the depth
  task automatic test_capacity_above_depth();
    write_capacity(7'd127);
    send_word(-32'sd500, 32'h0);
    send_word(32'sd500, 32'hffff_ffff);
  endtask

  // receiver stalls for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_request = HOLD_LEN;
    send_random(8);
  endtask

  // sender stops until every result is back, then resumes
  task automatic test_sender_pause();
    send_random(10);
    drain();
    send_random(10);
  endtask

  // fill the table in steps of capacity, so refusals land at many counts
  task automatic test_random_fill();
    int phase;
    logic [CNT_W-1:0] cap;
    phase = 0;
    while (shadow_fill < DEPTH && phase < 20) begin
      if ($urandom_range(5) == 0) cap = 7'd127;
      else cap = CNT_W'((shadow_fill + $urandom_range(1, 10) > DEPTH) ?
                        DEPTH : shadow_fill + $urandom_range(1, 10));
      write_capacity(cap);
      no_idle = (phase == 0);
      send_random(45);
      if (phase == 5) test_backpressure();
      if (phase == 7) test_sender_pause();
      phase++;
    end
    no_idle = 1'b0;
  endtask

  // full table under capacity 127, zero and the reset value, then random words up to the item count
  task automatic test_random_full();
    write_capacity(7'd127);
    send_random(60);
    write_capacity(7'd0);
    send_random(30);
    write_capacity(CAP_RESET);
    send_random(60);
    hold_request = HOLD_LEN;
    send_random(10);
    if (sent_count < ITEMS) send_random(ITEMS - sent_count);
  endtask

  // result checker and receiver idling
  initial begin
    insert_result_t want;
    int hold_cnt;
    hold_cnt = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: status %0d count %0d",
                     result_ch.status, result_ch.entry_count);
        end else begin
          want = pending_q.pop_front();
          if (result_ch.status !== want.status || result_ch.entry_count !== want.count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch key %0d: expected status %0d count %0d, got status %0d count %0d",
                       want.key, want.status, want.count,
                       result_ch.status, result_ch.entry_count);
          end
        end
      end
      if (hold_request > 0) begin
        hold_cnt = hold_request;
        hold_request = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_ch.ready <= 1'b0;
      end else if (no_idle) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    mismatches   = 0;
    no_idle      = 1'b0;
    hold_request = 0;
    sent_count   = 0;
    shadow_fill  = 0;
    shadow_cap   = CAP_RESET;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    item_ch.valid   <= 1'b0;
    item_ch.new_key <= '0;
    item_ch.payload <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_extremes();
    test_duplicates();
    test_capacity_zero();
    write_capacity(CAP_RESET);
    test_full_before_duplicate();
    test_capacity_lowered();
    test_capacity_above_depth();
    test_random_fill();
    test_random_full();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
